/* rtl/c2s_pkg.sv */
// Shared types and constants for the cartesian to spherical converter.
// Used by c2s_cordic and cartesian_to_spherical; depends on nothing.
package c2s_pkg;

   // field widths
   localparam int COORD_W         = 16;
   localparam int ANGLE_FRAC_BITS = 13;
   localparam int ANG_W           = ANGLE_FRAC_BITS + 3;
   localparam int AZ_W            = ANGLE_FRAC_BITS + 5;
   localparam int EL_W            = ANGLE_FRAC_BITS + 2;
   localparam int OFS_W           = 16;

   // cordic datapath widths
   localparam int ACC_FRAC = 30;
   localparam int ACC_W    = 34;
   localparam int CIN_W    = 34;
   localparam int CX_W     = 36;
   localparam int NORM_W   = 32;
   localparam int SHIFT_W  = 5;

   // square roots: radius uses COORD_W root bits, the xy length 32
   localparam int ELEV_ROOT_W = 32;
   localparam int ELEV_PAD_W  = 32 - COORD_W;

   // angle constants
   localparam logic signed [ACC_W-1:0] PI_Q30      = 34'sd3373259426;
   localparam logic signed [ACC_W-1:0] PI_HALF_Q30 = 34'sd1686629713;
   localparam logic [OFS_W-1:0]        TWO_PI_ANG  = 16'd51472;
   localparam logic [OFS_W-1:0]        HALF_PI_ANG = 16'd12868;

   typedef struct packed {
      logic signed [COORD_W-1:0] x_coord;
      logic signed [COORD_W-1:0] y_coord;
      logic signed [COORD_W-1:0] z_coord;
   } c2s_req_type;

   typedef struct packed {
      logic signed [AZ_W-1:0] azimuth;
      logic [EL_W-1:0]        elevation;
      logic [COORD_W-1:0]     radius;
      logic                   zero_radius;
   } c2s_rsp_type;

   // arctangent of 2^-i in radians with 30 fractional bits
   function automatic logic signed [ACC_W-1:0] atan_q30(input int idx);
      logic signed [ACC_W-1:0] val;
      case (idx)
         0:  val = 34'sd843314857;
         1:  val = 34'sd497837829;
         2:  val = 34'sd263043837;
         3:  val = 34'sd133525159;
         4:  val = 34'sd67021687;
         5:  val = 34'sd33543516;
         6:  val = 34'sd16775851;
         7:  val = 34'sd8388437;
         8:  val = 34'sd4194283;
         9:  val = 34'sd2097149;
         10: val = 34'sd1048576;
         11: val = 34'sd524288;
         12: val = 34'sd262144;
         13: val = 34'sd131072;
         14: val = 34'sd65536;
         15: val = 34'sd32768;
         16: val = 34'sd16384;
         17: val = 34'sd8192;
         18: val = 34'sd4096;
         19: val = 34'sd2048;
         20: val = 34'sd1024;
         21: val = 34'sd512;
         22: val = 34'sd256;
         23: val = 34'sd128;
         24: val = 34'sd64;
         25: val = 34'sd32;
         26: val = 34'sd16;
         27: val = 34'sd8;
         28: val = 34'sd4;
         29: val = 34'sd2;
         30: val = 34'sd1;
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

/* rtl/c2s_delay.sv */
// Delay line with one clock enable per stage, keeps side data aligned.
// Depends on nothing.
module c2s_delay #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic [DEPTH-1:0] en,
   input  logic [WIDTH-1:0] d_in,
   output logic [WIDTH-1:0] d_out
);

   logic [WIDTH-1:0] tap_ff [DEPTH];

   for (genvar k = 0; k < DEPTH; k++) begin : g_tap
      logic [WIDTH-1:0] tap_in;
      if (k == 0) begin : g_first
         assign tap_in = d_in;
      end else begin : g_next
         assign tap_in = tap_ff[k-1];
      end
      always_ff @(posedge clock) begin
         if (en[k]) begin
            tap_ff[k] <= tap_in;
         end
      end
   end

   assign d_out = tap_ff[DEPTH-1];

endmodule

/* rtl/c2s_isqrt.sv */
// Pipelined restoring integer square root, one root bit per stage.
// Gives floor root and remainder; depends on nothing.
module c2s_isqrt #(
   parameter int ROOT_W = 16
) (
   input  logic                  clock,
   input  logic [ROOT_W-1:0]     en,
   input  logic [2*ROOT_W-1:0]   rad_in,
   output logic [ROOT_W-1:0]     root_out,
   output logic [ROOT_W+1:0]     rem_out
);

   localparam int RAD_W = 2 * ROOT_W;
   localparam int REM_W = ROOT_W + 2;

   logic [RAD_W-1:0]  rad_ff  [ROOT_W];
   logic [ROOT_W-1:0] root_ff [ROOT_W];
   logic [REM_W-1:0]  rem_ff  [ROOT_W];

   for (genvar j = 0; j < ROOT_W; j++) begin : g_step
      logic [RAD_W-1:0]  rad_prev;
      logic [ROOT_W-1:0] root_prev;
      logic [REM_W-1:0]  rem_prev;
      logic [REM_W+1:0]  cur;
      logic [REM_W+1:0]  trial;
      logic [ROOT_W-1:0] root_in;
      logic [REM_W-1:0]  rem_in;

      if (j == 0) begin : g_first
         assign rad_prev  = rad_in;
         assign root_prev = '0;
         assign rem_prev  = '0;
      end else begin : g_next
         assign rad_prev  = rad_ff[j-1];
         assign root_prev = root_ff[j-1];
         assign rem_prev  = rem_ff[j-1];
      end

      // bring down two radicand bits and try the next root bit
      assign cur   = {rem_prev, rad_prev[RAD_W-1 -: 2]};
      assign trial = (REM_W+2)'({root_prev, 2'b01});

      always_comb begin
         if (cur >= trial) begin
            rem_in  = REM_W'(cur - trial);
            root_in = {root_prev[ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = cur[REM_W-1:0];
            root_in = {root_prev[ROOT_W-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (en[j]) begin
            rad_ff[j]  <= rad_prev << 2;
            root_ff[j] <= root_in;
            rem_ff[j]  <= rem_in;
         end
      end
   end

   assign root_out = root_ff[ROOT_W-1];
   assign rem_out  = rem_ff[ROOT_W-1];

endmodule

/* rtl/c2s_cordic.sv */
// Pipelined vectoring cordic giving atan2(y, x) rounded to the output angle format.
// Uses c2s_pkg for widths, pi constants and the arctangent table.
module c2s_cordic #(
   parameter int STEPS = 16
) (
   input  logic                                clock,
   input  logic [STEPS+3:0]                    en,
   input  logic signed [c2s_pkg::CIN_W-1:0]    y_in,
   input  logic signed [c2s_pkg::CIN_W-1:0]    x_in,
   output logic signed [c2s_pkg::ANG_W-1:0]    angle_out
);

   localparam int CIN_W = c2s_pkg::CIN_W;
   localparam int CX_W  = c2s_pkg::CX_W;
   localparam int ACC_W = c2s_pkg::ACC_W;
   localparam int NW    = c2s_pkg::NORM_W;
   localparam int SW    = c2s_pkg::SHIFT_W;
   localparam int RSH   = c2s_pkg::ACC_FRAC - c2s_pkg::ANGLE_FRAC_BITS;
   localparam logic signed [ACC_W-1:0] RND = ACC_W'(64'sd1 <<< (RSH - 1));

   // fold into the right half plane and catch the axis cases
   logic signed [CIN_W-1:0] xn_in, yn_in, ay;
   logic [NW-1:0]           m_in;
   logic signed [ACC_W-1:0] a0_in, spv_in;
   logic                    sp_in;

   always_comb begin
      xn_in = (x_in < 0) ? -x_in : x_in;
      yn_in = (x_in < 0) ? -y_in : y_in;
      ay    = (yn_in < 0) ? -yn_in : yn_in;
      m_in  = (xn_in > ay) ? xn_in[NW-1:0] : ay[NW-1:0];
      a0_in = '0;
      if (x_in < 0) begin
         a0_in = (y_in > 0) ? c2s_pkg::PI_Q30 : -c2s_pkg::PI_Q30;
      end
      sp_in  = 1'b0;
      spv_in = '0;
      if (y_in == 0) begin
         sp_in  = 1'b1;
         spv_in = (x_in < 0) ? c2s_pkg::PI_Q30 : '0;
      end else if (x_in == 0) begin
         sp_in  = 1'b1;
         spv_in = (y_in > 0) ? c2s_pkg::PI_HALF_Q30 : -c2s_pkg::PI_HALF_Q30;
      end
   end

   logic signed [CIN_W-1:0] xn0_ff, yn0_ff, xn1_ff, yn1_ff;
   logic [NW-1:0]           m0_ff;
   logic [SW-1:0]           sh1_ff;
   logic signed [ACC_W-1:0] a0_ff [2];
   logic                    sp_ff [STEPS+3];
   logic signed [ACC_W-1:0] spv_ff [STEPS+3];

   always_ff @(posedge clock) begin
      if (en[0]) begin
         xn0_ff    <= xn_in;
         yn0_ff    <= yn_in;
         m0_ff     <= m_in;
         a0_ff[0]  <= a0_in;
         sp_ff[0]  <= sp_in;
         spv_ff[0] <= spv_in;
      end
   end

   // leading zero count of the larger magnitude
   logic [SW-1:0] sh_in;
   always_comb begin
      sh_in = '0;
      for (int i = 0; i < NW; i++) begin
         if (m0_ff[i]) begin
            sh_in = SW'(NW - 1 - i);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         xn1_ff    <= xn0_ff;
         yn1_ff    <= yn0_ff;
         sh1_ff    <= sh_in;
         a0_ff[1]  <= a0_ff[0];
         sp_ff[1]  <= sp_ff[0];
         spv_ff[1] <= spv_ff[0];
      end
   end

   // normalize both operands by the common shift
   logic signed [CX_W-1:0] x_ff [STEPS+1];
   logic signed [CX_W-1:0] y_ff [STEPS+1];
   logic signed [ACC_W-1:0] a_ff [STEPS+1];

   always_ff @(posedge clock) begin
      if (en[2]) begin
         x_ff[0]   <= CX_W'(xn1_ff) <<< sh1_ff;
         y_ff[0]   <= CX_W'(yn1_ff) <<< sh1_ff;
         a_ff[0]   <= a0_ff[1];
         sp_ff[2]  <= sp_ff[1];
         spv_ff[2] <= spv_ff[1];
      end
   end

   // one micro-rotation per stage
   for (genvar i = 0; i < STEPS; i++) begin : g_iter
      logic signed [CX_W-1:0]  x_in_s, y_in_s;
      logic signed [ACC_W-1:0] a_in_s;
      always_comb begin
         if (y_ff[i] > 0) begin
            x_in_s = x_ff[i] + (y_ff[i] >>> i);
            y_in_s = y_ff[i] - (x_ff[i] >>> i);
            a_in_s = a_ff[i] + c2s_pkg::atan_q30(i);
         end else begin
            x_in_s = x_ff[i] - (y_ff[i] >>> i);
            y_in_s = y_ff[i] + (x_ff[i] >>> i);
            a_in_s = a_ff[i] - c2s_pkg::atan_q30(i);
         end
      end
      always_ff @(posedge clock) begin
         if (en[3+i]) begin
            x_ff[i+1]   <= x_in_s;
            y_ff[i+1]   <= y_in_s;
            a_ff[i+1]   <= a_in_s;
            sp_ff[i+3]  <= sp_ff[i+2];
            spv_ff[i+3] <= spv_ff[i+2];
         end
      end
   end

   // clamp to [-pi, pi], take axis value, round half up
   logic signed [ACC_W-1:0] a_sel, a_rnd;
   logic signed [c2s_pkg::ANG_W-1:0] angle_in, angle_ff;

   always_comb begin
      a_sel = a_ff[STEPS];
      if (a_sel > c2s_pkg::PI_Q30) begin
         a_sel = c2s_pkg::PI_Q30;
      end
      if (a_sel < -c2s_pkg::PI_Q30) begin
         a_sel = -c2s_pkg::PI_Q30;
      end
      if (sp_ff[STEPS+2]) begin
         a_sel = spv_ff[STEPS+2];
      end
      a_rnd    = (a_sel + RND) >>> RSH;
      angle_in = a_rnd[c2s_pkg::ANG_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (en[STEPS+3]) begin
         angle_ff <= angle_in;
      end
   end

   assign angle_out = angle_ff;

endmodule

/* rtl/cartesian_to_spherical.sv */
// Cartesian to spherical converter: azimuth, elevation and radius per beat.
// The pipeline length is set by the 32-stage xy square root ahead of the elevation
// cordic; throughput one beat per cycle while not stalled, gaps close up during stalls.
// Synchronous reset clears valid bits and loads the azimuth offset with pi/2.
// Depends on c2s_pkg, c2s_isqrt, c2s_cordic and c2s_delay.
module cartesian_to_spherical #(
   parameter int CORDIC_STEPS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  c2s_pkg::c2s_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output c2s_pkg::c2s_rsp_type rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [15:0]          csr_data
);

   localparam int CW     = c2s_pkg::COORD_W;
   localparam int EW     = c2s_pkg::ELEV_ROOT_W;
   localparam int CIN_W  = c2s_pkg::CIN_W;
   localparam int ANG_W  = c2s_pkg::ANG_W;
   localparam int CSTG   = CORDIC_STEPS + 4;
   // stage indexes
   localparam int EL_SQ0 = 2;
   localparam int EL_CO0 = EL_SQ0 + EW;
   localparam int LAST   = EL_CO0 + CSTG;
   localparam int DEPTH  = LAST + 1;
   localparam int AZ_END = EL_SQ0 + CSTG - 1;
   localparam int RD_END = EL_SQ0 + CW - 1;

   // offset register, reduced below 2*pi on write
   logic [c2s_pkg::OFS_W-1:0] ofs_ff, ofs_in;
   assign csr_ready = 1'b1;
   assign ofs_in = (csr_data >= c2s_pkg::TWO_PI_ANG) ? csr_data - c2s_pkg::TWO_PI_ANG
                                                     : csr_data;
   always_ff @(posedge clock) begin
      if (reset) begin
         ofs_ff <= c2s_pkg::HALF_PI_ANG;
      end else if (csr_valid && csr_ready) begin
         ofs_ff <= ofs_in;
      end
   end

   // per-stage valid and enable; a stage moves when empty or when the next moves
   logic             vld_ff [DEPTH];
   logic [DEPTH-1:0] en;

   always_comb begin
      en[DEPTH-1] = !vld_ff[DEPTH-1] || !rsp_stall;
      for (int k = DEPTH - 2; k >= 0; k--) begin
         en[k] = !vld_ff[k] || en[k+1];
      end
   end

   for (genvar k = 0; k < DEPTH; k++) begin : g_vld
      logic vld_in;
      if (k == 0) begin : g_first
         assign vld_in = req_valid;
      end else begin : g_next
         assign vld_in = vld_ff[k-1];
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (en[k]) begin
            vld_ff[k] <= vld_in;
         end
      end
   end

   assign req_stall = !en[0];
   assign rsp_valid = vld_ff[LAST];

   // stage a: register coordinates and squares
   logic signed [CW-1:0]   xa_ff, ya_ff, za_ff, xb_ff, yb_ff, zb_ff;
   logic signed [2*CW-1:0] xsq_in, ysq_in, zsq_in;
   logic [2*CW-1:0]        xsq_ff, ysq_ff, zsq_ff, sxy_ff, s3_ff;
   logic                   zra_ff, zrb_ff;

   assign xsq_in = req_data.x_coord * req_data.x_coord;
   assign ysq_in = req_data.y_coord * req_data.y_coord;
   assign zsq_in = req_data.z_coord * req_data.z_coord;

   always_ff @(posedge clock) begin
      if (en[0]) begin
         xa_ff  <= req_data.x_coord;
         ya_ff  <= req_data.y_coord;
         za_ff  <= req_data.z_coord;
         xsq_ff <= xsq_in;
         ysq_ff <= ysq_in;
         zsq_ff <= zsq_in;
         zra_ff <= (req_data.x_coord == 0) && (req_data.y_coord == 0)
                   && (req_data.z_coord == 0);
      end
   end

   // stage b: sums of squares
   always_ff @(posedge clock) begin
      if (en[1]) begin
         xb_ff  <= xa_ff;
         yb_ff  <= ya_ff;
         zb_ff  <= za_ff;
         sxy_ff <= xsq_ff + ysq_ff;
         s3_ff  <= xsq_ff + ysq_ff + zsq_ff;
         zrb_ff <= zra_ff;
      end
   end

   // radius square root, then hold root and remainder until the output stage
   logic [CW-1:0]   rad_root, rad_root_d;
   logic [CW+1:0]   rad_rem, rad_rem_d;

   c2s_isqrt #(.ROOT_W(CW)) u_rad_sqrt (
      .clock    (clock),
      .en       (en[RD_END:EL_SQ0]),
      .rad_in   (s3_ff),
      .root_out (rad_root),
      .rem_out  (rad_rem)
   );

   c2s_delay #(.WIDTH(2*CW+2), .DEPTH(LAST-1-RD_END)) u_rad_dly (
      .clock (clock),
      .en    (en[LAST-1:RD_END+1]),
      .d_in  ({rad_root, rad_rem}),
      .d_out ({rad_root_d, rad_rem_d})
   );

   // xy length, with z kept alongside
   logic [EW-1:0]        rxy;
   logic [EW+1:0]        rxy_rem;
   logic signed [CW-1:0] z_d;
   logic                 rxy_rem_unused;

   c2s_isqrt #(.ROOT_W(EW)) u_xy_sqrt (
      .clock    (clock),
      .en       (en[EL_CO0-1:EL_SQ0]),
      .rad_in   ({sxy_ff, (2*EW-2*CW)'(0)}),
      .root_out (rxy),
      .rem_out  (rxy_rem)
   );

   c2s_delay #(.WIDTH(CW+1), .DEPTH(EW)) u_z_dly (
      .clock (clock),
      .en    (en[EL_CO0-1:EL_SQ0]),
      .d_in  ({zb_ff, rxy_rem[0]}),
      .d_out ({z_d, rxy_rem_unused})
   );

   // elevation cordic: atan2(rxy, z)
   logic signed [CIN_W-1:0] el_y, el_x;
   logic signed [ANG_W-1:0] el_ang;
   assign el_y = CIN_W'(rxy);
   assign el_x = CIN_W'($signed({z_d, (c2s_pkg::ELEV_PAD_W)'(0)}));

   c2s_cordic #(.STEPS(CORDIC_STEPS)) u_el_cordic (
      .clock     (clock),
      .en        (en[LAST-1:EL_CO0]),
      .y_in      (el_y),
      .x_in      (el_x),
      .angle_out (el_ang)
   );

   // azimuth cordic: atan2(y, x), then delayed to meet elevation
   logic signed [CIN_W-1:0] az_y, az_x;
   logic signed [ANG_W-1:0] az_ang, az_ang_d;
   assign az_y = CIN_W'(yb_ff);
   assign az_x = CIN_W'(xb_ff);

   c2s_cordic #(.STEPS(CORDIC_STEPS)) u_az_cordic (
      .clock     (clock),
      .en        (en[AZ_END:EL_SQ0]),
      .y_in      (az_y),
      .x_in      (az_x),
      .angle_out (az_ang)
   );

   c2s_delay #(.WIDTH(ANG_W), .DEPTH(LAST-1-AZ_END)) u_az_dly (
      .clock (clock),
      .en    (en[LAST-1:AZ_END+1]),
      .d_in  (az_ang),
      .d_out (az_ang_d)
   );

   logic zr_d;
   c2s_delay #(.WIDTH(1), .DEPTH(LAST-EL_SQ0)) u_zr_dly (
      .clock (clock),
      .en    (en[LAST-1:EL_SQ0]),
      .d_in  (zrb_ff),
      .d_out (zr_d)
   );

   // output stage: offset add, elevation clamp, radius rounding
   c2s_pkg::c2s_rsp_type rsp_in, rsp_ff;

   always_comb begin
      rsp_in.azimuth = c2s_pkg::AZ_W'(az_ang_d) + $signed(c2s_pkg::AZ_W'(ofs_ff));
      if (zr_d) begin
         rsp_in.elevation = c2s_pkg::EL_W'(c2s_pkg::HALF_PI_ANG);
      end else if (el_ang < 0) begin
         rsp_in.elevation = '0;
      end else begin
         rsp_in.elevation = el_ang[c2s_pkg::EL_W-1:0];
      end
      rsp_in.radius = rad_root_d + CW'(rad_rem_d > (CW+2)'(rad_root_d));
      rsp_in.zero_radius = zr_d;
   end

   always_ff @(posedge clock) begin
      if (en[LAST]) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_data = rsp_ff;

endmodule
